// File: src/tdsp_pkg.sv
// shared types, constants and functions of the tpdf dither sample packer
package tdsp_pkg;

  localparam int unsigned WordW        = 32;
  localparam int unsigned SampleW      = 24;
  localparam int unsigned PcmW         = 16;
  localparam int unsigned CountW       = 2;
  localparam int unsigned FrameW       = 10;
  localparam int unsigned CfgDataW     = FrameW;
  localparam int unsigned DefMaxFrameWords = 512;

  localparam logic [WordW-1:0]  SeedReset  = 32'h1f2e3d4c;
  localparam logic [FrameW-1:0] FrameReset = 10'd96;

  localparam logic [CountW-1:0] BytesPcm16 = 2'd2;
  localparam logic [CountW-1:0] BytesPcm24 = 2'd3;

  localparam logic signed [17:0] SatMax = 18'sd32767;
  localparam logic signed [17:0] SatMin = -18'sd32768;
  localparam logic signed [25:0] RoundBias = 26'sd128;

  typedef enum logic [0:0] {
    REG_DITHER_MODE = 1'b0,
    REG_FRAME_WORDS = 1'b1
  } cfg_reg_e;

  // one xorshift32 step, shifts 13, 17, 5
  function automatic logic [WordW-1:0] xorshift32(input logic [WordW-1:0] x);
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

// File: src/tdsp_if.sv
// stream interfaces for capture words and packed samples
interface tdsp_in_if;
  import tdsp_pkg::*;
  logic             valid;
  logic             ready;
  logic [WordW-1:0] capture_word;

  modport source (output valid, output capture_word, input ready);
  modport sink   (input valid, input capture_word, output ready);
endinterface

interface tdsp_out_if;
  import tdsp_pkg::*;
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] sample_bytes;
  logic [CountW-1:0]  byte_count;
  logic               frame_last;

  modport source (output valid, output sample_bytes, output byte_count, output frame_last,
                  input ready);
  modport sink   (input valid, input sample_bytes, input byte_count, input frame_last,
                  output ready);
endinterface

// File: src/tdsp_dither.sv
// tpdf dither generator and 24 to 16 bit requantizer with saturation
module tdsp_dither import tdsp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  logic [SampleW-1:0] sample_i,
  output logic [PcmW-1:0]    pcm_o
);

  logic [WordW-1:0]  seed_q, seed_d;
  logic [WordW-1:0]  draw1, draw2;
  logic signed [8:0]  tpdf;
  logic signed [25:0] sum;
  logic signed [17:0] shifted;

  assign draw1  = xorshift32(seed_q);
  assign draw2  = xorshift32(draw1);
  assign seed_d = advance_i ? draw2 : seed_q;

  assign tpdf = $signed({1'b0, draw1[31:24]}) - $signed({1'b0, draw2[31:24]});
  assign sum  = 26'($signed(sample_i)) + 26'(tpdf) + RoundBias;
  // arithmetic shift gives floor
  assign shifted = sum[25:8];

  always_comb begin
    if (shifted > SatMax) begin
      pcm_o = SatMax[PcmW-1:0];
    end else if (shifted < SatMin) begin
      pcm_o = SatMin[PcmW-1:0];
    end else begin
      pcm_o = shifted[PcmW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SeedReset;
    end else begin
      seed_q <= seed_d;
    end
  end

endmodule

// File: src/tdsp_frame_ctr.sv
// word position counter that flags the last sample of each frame
module tdsp_frame_ctr import tdsp_pkg::*; #(
  parameter int unsigned MAX_FRAME_WORDS = DefMaxFrameWords
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [FrameW-1:0] frame_words_i,
  output logic              last_o
);

  localparam int unsigned PosW = $clog2(MAX_FRAME_WORDS);
  localparam int unsigned LenW = $clog2(MAX_FRAME_WORDS + 1);
  localparam int unsigned CmpW = ((LenW > FrameW) ? LenW : FrameW) + 1;
  localparam logic [CmpW-1:0] MaxLen = CmpW'(MAX_FRAME_WORDS);

  logic [PosW-1:0] pos_q, pos_d;
  logic [CmpW-1:0] len;
  logic [CmpW-1:0] pos_next;

  always_comb begin
    len = CmpW'(frame_words_i);
    if (len == '0) begin
      len = CmpW'(1);
    end else if (len > MaxLen) begin
      len = MaxLen;
    end
  end

  assign pos_next = CmpW'(pos_q) + CmpW'(1);
  assign last_o   = (pos_next >= len);

  always_comb begin
    pos_d = pos_q;
    if (step_i) begin
      pos_d = last_o ? '0 : pos_next[PosW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// File: src/tpdf_dither_sample_packer_unit.sv
// top level of the tpdf dither sample packer
//
// Takes one raw 32-bit capture word per transfer on in_ch (sample in bits 30..7)
// and returns one packed sample per word on out_ch. With dither_mode at 0 the
// 24-bit sample passes through as three little-endian bytes (byte_count 3);
// with dither_mode at 1 two xorshift32 draws form tpdf dither, the sample is
// rounded to 16 bits with saturation and byte_count is 2. frame_last marks
// the word that closes each frame of frame_words words.
// Configuration is to be written through cfg_we_i / cfg_idx_i / cfg_data_i only
// while the block holds no word in flight; the block itself does not enforce it.
// An input transfer is captured in the input register; then the requantizer,
// the prng and the frame counter feed the output register in the same cycle.
// Throughput is one word per cycle while out_ch does not stall.
// Reset clears the prng to its seed, the frame position to zero, the mode to
// pass-through and the frame length to 96. When out_ch stalls the result is
// held in the output register and one more word is still taken into the input
// register; only then does in_ch.ready drop.
module tpdf_dither_sample_packer_unit import tdsp_pkg::*; #(
  parameter int unsigned MAX_FRAME_WORDS = DefMaxFrameWords
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  tdsp_in_if.sink             in_ch,
  tdsp_out_if.source          out_ch,
  input  logic                cfg_we_i,
  input  cfg_reg_e            cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic              dither_mode_q;
  logic [FrameW-1:0] frame_words_q;

  logic             s1_valid_q;
  logic [WordW-1:0] s1_word_q;
  logic             s1_adv;
  logic             step;
  logic             in_fire;

  logic               out_valid_q;
  logic [SampleW-1:0] out_bytes_q, out_bytes_d;
  logic [CountW-1:0]  out_count_q, out_count_d;
  logic               out_last_q;

  logic [SampleW-1:0] raw24;
  logic [PcmW-1:0]    pcm;
  logic               last;

  assign s1_adv      = !out_valid_q || out_ch.ready;
  assign in_ch.ready = !s1_valid_q || s1_adv;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign step        = s1_valid_q && s1_adv;
  assign raw24       = s1_word_q[30:7];

  tdsp_dither u_dither (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (step && dither_mode_q),
    .sample_i  (raw24),
    .pcm_o     (pcm)
  );

  tdsp_frame_ctr #(
    .MAX_FRAME_WORDS (MAX_FRAME_WORDS)
  ) u_frame_ctr (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .frame_words_i (frame_words_q),
    .last_o        (last)
  );

  always_comb begin
    if (dither_mode_q) begin
      out_bytes_d = SampleW'(pcm);
      out_count_d = BytesPcm16;
    end else begin
      out_bytes_d = raw24;
      out_count_d = BytesPcm24;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dither_mode_q <= 1'b0;
      frame_words_q <= FrameReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DITHER_MODE: dither_mode_q <= cfg_data_i[0];
        REG_FRAME_WORDS: frame_words_q <= cfg_data_i[FrameW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_q <= in_ch.valid;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_word_q <= in_ch.capture_word;
    end
    if (step) begin
      out_bytes_q <= out_bytes_d;
      out_count_q <= out_count_d;
      out_last_q  <= last;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.sample_bytes = out_bytes_q;
  assign out_ch.byte_count   = out_count_q;
  assign out_ch.frame_last   = out_last_q;

  // a held word in the input stage is never dropped
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> s1_valid_q)
    else $error("input stage word lost while output stalled");

  // taking a word into a full input stage requires it to move on
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s1_valid_q) |-> s1_adv)
    else $error("input stage overwritten");

  // 16-bit results leave the top byte clear
  a_pcm16_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_count_q == BytesPcm16) |-> (out_bytes_q[23:16] == '0))
    else $error("dithered sample has nonzero top byte");

endmodule

// File: dv/testbench.sv
// testbench for the tpdf dither sample packer: directed table, random phases, predictor check
`timescale 1ns / 1ps

module testbench;
  import tdsp_pkg::*;

  typedef struct packed {
    logic [SampleW-1:0] pcm;
    logic [CountW-1:0]  nbytes;
    logic               last;
  } sample_t;

  // one row of the directed table: a register write or a capture word
  typedef struct packed {
    logic                is_cfg;
    cfg_reg_e            reg_idx;
    logic [CfgDataW-1:0] reg_val;
    logic [WordW-1:0]    word;
    logic                typed;
    sample_t             want;
  } step_row_t;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_e;

  localparam int unsigned FrameCap    = DefMaxFrameWords;
  localparam int unsigned Latency     = 2;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned Phases      = 10;
  localparam int unsigned PhaseItems  = 175;
  localparam int unsigned PressurePh  = 4;
  localparam int unsigned MaxPrinted  = 50;
  localparam int unsigned NumDirected = 29;

  localparam step_row_t DirectedSteps [NumDirected] = '{
    '{1'b0, REG_DITHER_MODE, 10'd0, 32'h0000_0000, 1'b1, '{24'h000000, BytesPcm24, 1'b0}},
    '{1'b0, REG_DITHER_MODE, 10'd0, 32'hFFFF_FFFF, 1'b1, '{24'hFFFFFF, BytesPcm24, 1'b0}},
    '{1'b0, REG_DITHER_MODE, 10'd0, 32'h3FFF_FF80, 1'b1, '{24'h7FFFFF, BytesPcm24, 1'b0}},
    '{1'b0, REG_DITHER_MODE, 10'd0, 32'h4000_0000, 1'b1, '{24'h800000, BytesPcm24, 1'b0}},
    // bit 31 and the low seven bits carry nothing
    '{1'b0, REG_DITHER_MODE, 10'd0, 32'h8000_007F, 1'b1, '{24'h000000, BytesPcm24, 1'b0}},
    '{1'b0, REG_DITHER_MODE, 10'd0, 32'h2AAA_AAAA, 1'b0, '0},
    // zero length while mid-frame: acts as one
    '{1'b1, REG_FRAME_WORDS, 10'd0, 32'h0, 1'b0, '0},
    '{1'b0, REG_DITHER_MODE, 10'd0, 32'h1234_5678, 1'b0, '0},
    '{1'b0, REG_DITHER_MODE, 10'd0, 32'h7FFF_FFFF, 1'b1, '{24'hFFFFFF, BytesPcm24, 1'b1}},
    '{1'b1, REG_FRAME_WORDS, 10'd1, 32'h0, 1'b0, '0},
    '{1'b0, REG_DITHER_MODE, 10'd0, 32'h0000_0000, 1'b1, '{24'h000000, BytesPcm24, 1'b1}},
    '{1'b1, REG_DITHER_MODE, 10'd1, 32'h0, 1'b0, '0},
    '{1'b1, REG_FRAME_WORDS, 10'd3, 32'h0, 1'b0, '0},
    // full-scale positive always clips to the top code
    '{1'b0, REG_DITHER_MODE, 10'd0, 32'h3FFF_FF80, 1'b1, '{24'h007FFF, BytesPcm16, 1'b0}},
    '{1'b0, REG_DITHER_MODE, 10'd0, 32'h4000_0000, 1'b0, '0},
    '{1'b0, REG_DITHER_MODE, 10'd0, 32'h0000_0000, 1'b0, '0},
    '{1'b0, REG_DITHER_MODE, 10'd0, 32'hFFFF_FFFF, 1'b0, '0},
    '{1'b0, REG_DITHER_MODE, 10'd0, 32'hBFFF_FF80, 1'b0, '0},
    // oversized length clamps to the maximum
    '{1'b1, REG_FRAME_WORDS, 10'd1023, 32'h0, 1'b0, '0},
    '{1'b0, REG_DITHER_MODE, 10'd0, 32'h0000_0080, 1'b0, '0},
    '{1'b0, REG_DITHER_MODE, 10'd0, 32'h7FFF_FF80, 1'b0, '0},
    '{1'b1, REG_FRAME_WORDS, 10'd512, 32'h0, 1'b0, '0},
    '{1'b0, REG_DITHER_MODE, 10'd0, 32'h5555_5555, 1'b0, '0},
    // mode flip mid-frame keeps the word position
    '{1'b1, REG_DITHER_MODE, 10'd0, 32'h0, 1'b0, '0},
    '{1'b0, REG_DITHER_MODE, 10'd0, 32'hAAAA_AAAA, 1'b0, '0},
    '{1'b1, REG_FRAME_WORDS, 10'd2, 32'h0, 1'b0, '0},
    '{1'b0, REG_DITHER_MODE, 10'd0, 32'h0000_0000, 1'b0, '0},
    '{1'b0, REG_DITHER_MODE, 10'd0, 32'hFFFF_FFFF, 1'b0, '0},
    '{1'b1, REG_FRAME_WORDS, 10'd96, 32'h0, 1'b0, '0}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  cfg_reg_e            cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  tdsp_in_if  in_ch ();
  tdsp_out_if out_ch ();

  tpdf_dither_sample_packer_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // predictor copy of the block state
  logic             mode_q;
  logic [FrameW-1:0] frame_q;
  logic [WordW-1:0] seed_q;
  int unsigned      pos_q;

  sample_t pending_q [$];
  int      err_count    = 0;
  int      hold_trigger = 0;
  idle_e   idle_mode    = IDLE_NONE;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [WordW-1:0] prng_step(input logic [WordW-1:0] s);
    logic [WordW-1:0] t;
    t = s ^ {s[18:0], 13'd0};
    t = t ^ {17'd0, t[31:17]};
    return t ^ {t[26:0], 5'd0};
  endfunction

  function automatic sample_t pack_next(input logic [WordW-1:0] word);
    sample_t                   r;
    logic signed [SampleW-1:0] s24;
    int                        acc;
    int unsigned               len;
    s24 = word[30:7];
    if (mode_q) begin
      seed_q = prng_step(seed_q);
      acc = int'(s24) + 128 + int'(seed_q[31:24]);
      seed_q = prng_step(seed_q);
      acc = (acc - int'(seed_q[31:24])) >>> 8;
      if (acc > 32767) acc = 32767;
      if (acc < -32768) acc = -32768;
      r.pcm = {8'h00, acc[15:0]};
      r.nbytes = BytesPcm16;
    end else begin
      r.pcm = word[30:7];
      r.nbytes = BytesPcm24;
    end
    len = frame_q;
    if (len == 0) len = 1;
    else if (len > FrameCap) len = FrameCap;
    if (pos_q + 1 >= len) begin
      r.last = 1'b1;
      pos_q = 0;
    end else begin
      r.last = 1'b0;
      pos_q++;
    end
    return r;
  endfunction

  function automatic bit sender_waits();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(99) < 87;
      IDLE_BOTH: return $urandom_range(99) < 10;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(99) < 87;
      IDLE_BOTH: return $urandom_range(99) < 10;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic logic [FrameW-1:0] pick_frame();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return FrameW'($urandom_range(12, 1));
    if (r < 78) return '0;
    if (r < 84) return FrameW'(FrameCap);
    if (r < 90) return FrameW'($urandom_range(1023, FrameCap + 1));
    return FrameW'($urandom);
  endfunction

  function automatic logic [WordW-1:0] random_word();
    logic [SampleW-1:0] s;
    if ($urandom_range(7) != 0) return $urandom;
    // samples at and around full scale
    case ($urandom_range(4))
      0:       s = 24'h7FFFFF;
      1:       s = 24'h800000;
      2:       s = 24'h7FFF7F;
      3:       s = 24'h800080;
      default: s = 24'hFFFFFF;
    endcase
    return {1'($urandom), s, 7'($urandom)};
  endfunction

  task automatic note_mismatch(input string msg);
    if (err_count < MaxPrinted) $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_DITHER_MODE) mode_q = val[0];
    else frame_q = val[FrameW-1:0];
  endtask

  // drain everything in flight before touching the registers
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  task automatic push_word(input logic [WordW-1:0] word, input logic typed, input sample_t want);
    sample_t pred;
    while (sender_waits()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.capture_word <= word;
    do @(posedge clk_i); while (!in_ch.ready);
    pred = pack_next(word);
    pending_q.push_back(typed ? want : pred);
  endtask

  initial begin : sample_sink
    sample_t got;
    sample_t want;
    int      hold_left;
    int      hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.sample_bytes, out_ch.byte_count, out_ch.frame_last};
        if (pending_q.size() == 0) begin
          note_mismatch($sformatf("unexpected transfer %h", got));
        end else begin
          want = pending_q.pop_front();
          if (got.pcm !== want.pcm)
            note_mismatch($sformatf("sample_bytes %h, want %h", got.pcm, want.pcm));
          if (got.nbytes !== want.nbytes)
            note_mismatch($sformatf("byte_count %0d, want %0d", got.nbytes, want.nbytes));
          if (got.last !== want.last)
            note_mismatch($sformatf("frame_last %0b, want %0b", got.last, want.last));
        end
      end
      if (hold_seen != hold_trigger) begin
        hold_seen = hold_trigger;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= !receiver_stalls();
      end
    end
  end

  initial begin : stimulus
    logic mode_bit;
    rst_ni <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.capture_word <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= REG_DITHER_MODE;
    cfg_data_i <= '0;
    mode_q = 1'b0;
    frame_q = FrameReset;
    seed_q = SeedReset;
    pos_q = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedSteps[i]) begin
      if (DirectedSteps[i].is_cfg) begin
        settle();
        write_reg(DirectedSteps[i].reg_idx, DirectedSteps[i].reg_val);
      end else begin
        push_word(DirectedSteps[i].word, DirectedSteps[i].typed, DirectedSteps[i].want);
      end
    end

    for (int ph = 0; ph < Phases; ph++) begin
      settle();
      mode_bit = (ph < 2) ? ph[0] : 1'($urandom_range(1));
      // upper data bits are junk for the one-bit mode register
      write_reg(REG_DITHER_MODE, {9'($urandom), mode_bit});
      write_reg(REG_FRAME_WORDS, pick_frame());
      idle_mode = idle_e'(ph % 4);
      if (ph == PressurePh) hold_trigger++;
      repeat (PhaseItems) push_word(random_word(), 1'b0, '0);
    end

    settle();
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
